### rtl/glw_pkg.sv
`default_nettype none

package glw_pkg;

	localparam int MAX_ENTRIES = 4096;
	localparam int LAT_W       = 28;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int LEN_W       = IDX_W + 1;
	localparam int HALF_W      = 12;
	localparam int TOL_W       = 20;
	localparam int ROW_W       = 13;
	localparam int MODE_W      = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 20;

	localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EMIT   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_HALF_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_LOC_RES,
		ST_EMIT,
		ST_NOCUR
	} glw_state_t;

	typedef struct packed {
		logic load_wr;
		logic search_init;
		logic probe_rd;
		logic probe_step;
		logic cursor_rd;
		logic res_locate;
		logic res_emit;
		logic res_invalid;
	} glw_cmd_t;

	typedef struct packed {
		logic len_zero;
		logic cursor_valid;
		logic hit;
		logic search_end;
		logic out_free;
	} glw_stat_t;

endpackage

`default_nettype wire

### rtl/gaussian_latitude_locate_and_walk.sv
// Sequencing: a load item gives no result; an emit reads the cursor entry into the read
// register and loads the output register in ST_EMIT; a locate runs a read (ST_PROBE) and
// a compare (ST_CMP) per probe, up to 13 probes at 4096 entries, then ST_LOC_RES, which
// an empty table enters at once. Throughput: one item at a time; the next item is taken
// the cycle after the result loads; loads run every cycle; a stalled result holds input.
// Reset clears cursor, walk state and handshakes, loads register defaults; table uncleared.
`default_nettype none

module gaussian_latitude_locate_and_walk (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// Configuration write port.
	input  wire logic                               cfg_write,
	input  wire logic [glw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [glw_pkg::CFG_DATA_W-1:0]     cfg_data,
	// Input item channel.
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [glw_pkg::MODE_W-1:0]         mode,
	input  wire logic [glw_pkg::IDX_W-1:0]          entry_index,
	input  wire logic signed [glw_pkg::LAT_W-1:0]   latitude,
	input  wire logic                               scan_north,
	// Result item channel.
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [glw_pkg::IDX_W-1:0]               found_index,
	output logic                                    not_found,
	output logic signed [glw_pkg::LAT_W-1:0]        row_latitude,
	output logic                                    last_row
);
	import glw_pkg::*;

	// The controller sequences the binary search probes and the row emits,
	// while the datapath owns the table memory, the search bounds, the cursor
	// and the output register. They talk only through these two structs.
	glw_cmd_t  cmd;
	glw_stat_t stat;

	glw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Each probe reads the entry at the midpoint of the bounds into the read register and
	// compares it in the cycle after. A miss with the sought latitude above the entry stops
	// the search when the upper bound would fall below index zero.
	glw_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.entry_index  (entry_index),
		.latitude     (latitude),
		.scan_north   (scan_north),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found_index  (found_index),
		.not_found    (not_found),
		.row_latitude (row_latitude),
		.last_row     (last_row)
	);

endmodule

`default_nettype wire

### rtl/glw_ctrl.sv
`default_nettype none

module glw_ctrl (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [glw_pkg::MODE_W-1:0]   mode,
	input  wire glw_pkg::glw_stat_t           stat,
	output glw_pkg::glw_cmd_t                 cmd
);
	import glw_pkg::*;

	glw_state_t state_q;
	glw_state_t state_nxt;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_LOCATE: state_nxt = stat.len_zero ? ST_LOC_RES : ST_PROBE;
						MODE_EMIT:   state_nxt = stat.cursor_valid ? ST_EMIT : ST_NOCUR;
						default:     state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_PROBE: state_nxt = ST_CMP;
			ST_CMP: begin
				if (stat.hit || stat.search_end) begin
					state_nxt = ST_LOC_RES;
				end else begin
					state_nxt = ST_PROBE;
				end
			end
			ST_LOC_RES, ST_EMIT, ST_NOCUR: begin
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_LOAD:   cmd.load_wr     = 1'b1;
						MODE_LOCATE: cmd.search_init = 1'b1;
						MODE_EMIT:   cmd.cursor_rd   = stat.cursor_valid;
						default:     cmd = '0;
					endcase
				end
			end
			ST_PROBE:   cmd.probe_rd    = 1'b1;
			ST_CMP:     cmd.probe_step  = 1'b1;
			ST_LOC_RES: cmd.res_locate  = stat.out_free;
			ST_EMIT:    cmd.res_emit    = stat.out_free;
			ST_NOCUR:   cmd.res_invalid = stat.out_free;
			default:    cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/glw_datapath.sv
`default_nettype none

module glw_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_write,
	input  wire logic [glw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [glw_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic [glw_pkg::IDX_W-1:0]           entry_index,
	input  wire logic signed [glw_pkg::LAT_W-1:0]    latitude,
	input  wire logic                                scan_north,
	input  wire glw_pkg::glw_cmd_t                   cmd,
	output glw_pkg::glw_stat_t                       stat,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [glw_pkg::IDX_W-1:0]                found_index,
	output logic                                     not_found,
	output logic signed [glw_pkg::LAT_W-1:0]         row_latitude,
	output logic                                     last_row
);
	import glw_pkg::*;

	// Configuration registers.
	logic [HALF_W-1:0] half_count_q;
	logic [TOL_W-1:0]  tolerance_q;
	logic [ROW_W-1:0]  row_count_q;

	// Latitude table and its registered read port.
	logic [LAT_W-1:0] table_mem [MAX_ENTRIES];
	logic [LAT_W-1:0] rd_data_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;

	// Search registers.
	logic signed [LAT_W-1:0] lat_q;
	logic                    north_q;
	logic [LEN_W-1:0]        lo_q;
	logic [IDX_W-1:0]        hi_q;
	logic [IDX_W-1:0]        mid_q;
	logic                    found_q;
	logic [IDX_W-1:0]        hit_q;

	// Walker state.
	logic [IDX_W-1:0] cursor_q;
	logic             walk_down_q;
	logic [ROW_W-1:0] rows_q;
	logic             cursor_valid_q;

	logic [LEN_W-1:0] half_x2;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] len_m1;
	logic [LEN_W:0]   mid_sum;
	logic [IDX_W-1:0] mid_calc;
	logic signed [LAT_W:0] diff;
	logic [LAT_W:0]   abs_diff;
	logic             hit;
	logic             go_low;
	logic [LEN_W-1:0] lo_next;
	logic [IDX_W-1:0] hi_next;
	logic             search_end;
	logic [ROW_W-1:0] row_limit;
	logic [ROW_W-1:0] rows_inc;
	logic             is_last;
	logic [LEN_W-1:0] cursor_inc;
	logic [IDX_W-1:0] cursor_step;
	logic             out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_count_q <= HALF_W'(1);
			tolerance_q  <= TOL_W'(1000);
			row_count_q  <= ROW_W'(1);
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_HALF_COUNT: half_count_q <= cfg_data[HALF_W-1:0];
				CFG_TOLERANCE:  tolerance_q  <= cfg_data[TOL_W-1:0];
				CFG_ROW_COUNT:  row_count_q  <= cfg_data[ROW_W-1:0];
				default:        half_count_q <= half_count_q;
			endcase
		end
	end

	// Active length is twice the half count, saturated to the table size.
	assign half_x2 = {half_count_q, 1'b0};
	assign len     = (half_x2 > LEN_W'(MAX_ENTRIES)) ? LEN_W'(MAX_ENTRIES) : half_x2;
	assign len_m1  = len - LEN_W'(1);

	assign mid_sum  = {1'b0, lo_q} + {2'b00, hi_q};
	assign mid_calc = mid_sum[IDX_W:1];

	assign rd_en   = cmd.probe_rd || cmd.cursor_rd;
	assign rd_addr = cmd.cursor_rd ? cursor_q : mid_calc;

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			table_mem[entry_index] <= latitude;
		end
		if (rd_en) begin
			rd_data_q <= table_mem[rd_addr];
		end
	end

	// Probe compare against the entry read at mid.
	assign diff     = {lat_q[LAT_W-1], lat_q} - {rd_data_q[LAT_W-1], rd_data_q};
	assign abs_diff = diff[LAT_W] ? ((LAT_W+1)'(0) - diff) : diff;
	assign hit      = abs_diff <= {{(LAT_W+1-TOL_W){1'b0}}, tolerance_q};
	assign go_low   = diff[LAT_W];
	assign lo_next  = {1'b0, mid_q} + LEN_W'(1);
	assign hi_next  = mid_q - IDX_W'(1);

	always_comb begin
		if (go_low) begin
			search_end = lo_next > {1'b0, hi_q};
		end else begin
			search_end = (mid_q == '0) || ({1'b0, hi_next} < lo_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search_init) begin
			lat_q   <= latitude;
			north_q <= scan_north;
			lo_q    <= '0;
			hi_q    <= len_m1[IDX_W-1:0];
			found_q <= 1'b0;
			hit_q   <= '0;
		end
		if (cmd.probe_rd) begin
			mid_q <= mid_calc;
		end
		if (cmd.probe_step) begin
			if (hit) begin
				found_q <= 1'b1;
				hit_q   <= mid_q;
			end else if (go_low) begin
				lo_q <= lo_next;
			end else begin
				hi_q <= hi_next;
			end
		end
	end

	// Row counting and cursor stepping for an emitted row.
	assign row_limit  = (row_count_q == '0) ? ROW_W'(1) : row_count_q;
	assign rows_inc   = rows_q + ROW_W'(1);
	assign is_last    = rows_inc >= row_limit;
	assign cursor_inc = {1'b0, cursor_q} + LEN_W'(1);

	always_comb begin
		if (walk_down_q) begin
			if (cursor_q != '0) begin
				cursor_step = cursor_q - IDX_W'(1);
			end else if (len == '0) begin
				cursor_step = '0;
			end else begin
				cursor_step = len_m1[IDX_W-1:0];
			end
		end else if (cursor_inc >= len) begin
			cursor_step = '0;
		end else begin
			cursor_step = cursor_inc[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q       <= '0;
			walk_down_q    <= 1'b0;
			rows_q         <= '0;
			cursor_valid_q <= 1'b0;
		end else if (cmd.res_locate) begin
			if (found_q) begin
				cursor_q       <= hit_q;
				walk_down_q    <= north_q;
				rows_q         <= '0;
				cursor_valid_q <= 1'b1;
			end else begin
				cursor_valid_q <= 1'b0;
			end
		end else if (cmd.res_emit) begin
			rows_q   <= is_last ? '0 : rows_inc;
			cursor_q <= cursor_step;
		end
	end

	// Output register; a new result loads as the previous one is taken.
	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.res_locate || cmd.res_emit || cmd.res_invalid) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_locate) begin
			found_index  <= found_q ? hit_q : '0;
			not_found    <= !found_q;
			row_latitude <= '0;
			last_row     <= 1'b0;
		end else if (cmd.res_emit) begin
			found_index  <= cursor_q;
			not_found    <= 1'b0;
			row_latitude <= rd_data_q;
			last_row     <= is_last;
		end else if (cmd.res_invalid) begin
			found_index  <= '0;
			not_found    <= 1'b1;
			row_latitude <= '0;
			last_row     <= 1'b0;
		end
	end

	assign stat.len_zero     = (len == '0);
	assign stat.cursor_valid = cursor_valid_q;
	assign stat.hit          = hit;
	assign stat.search_end   = search_end;
	assign stat.out_free     = out_free;

endmodule

`default_nettype wire

### tb/sv/glw_tb_pkg.sv
`default_nettype none

package glw_tb_pkg;

	import glw_pkg::*;

	// Mode 3 is accepted by the block and dropped without a result.
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	typedef logic signed [LAT_W-1:0] lat_t;
	typedef logic [IDX_W-1:0]        idx_t;

	typedef struct {
		idx_t index;
		logic miss;
		lat_t lat;
		logic last;
	} row_t;

	class lat_walk_board;
		lat_t              shadow_lat [MAX_ENTRIES];
		bit                written [MAX_ENTRIES];
		idx_t              cursor;
		bit                walk_down;
		logic [ROW_W-1:0]  rows_emitted;
		bit                cursor_valid;
		logic [HALF_W-1:0] half_count;
		logic [TOL_W-1:0]  tolerance;
		logic [ROW_W-1:0]  row_count;
		row_t              expected_rows [$];
		int                errors;

		function new();
			cursor = '0;
			walk_down = 1'b0;
			rows_emitted = '0;
			cursor_valid = 1'b0;
			half_count = 12'd1;
			tolerance = 20'd1000;
			row_count = 13'd1;
			errors = 0;
			foreach (written[i]) written[i] = 1'b0;
		endfunction

		function void report(string what, longint got, longint want);
			errors++;
			if (errors <= 200) begin
				$display("mismatch in %s: got %0d, expected %0d", what, got, want);
			end
		endfunction

		function int active_len();
			int len;
			len = 2 * int'(half_count);
			return (len > MAX_ENTRIES) ? MAX_ENTRIES : len;
		endfunction

		function int pending();
			return expected_rows.size();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
			CFG_HALF_COUNT: begin
				half_count = data[HALF_W-1:0];
			end
			CFG_TOLERANCE: begin
				tolerance = data[TOL_W-1:0];
			end
			CFG_ROW_COUNT: begin
				row_count = data[ROW_W-1:0];
			end
			default: begin
			end
			endcase
		endfunction

		// Tolerant binary search over the active part of a descending table.
		// gap reports the first probe of an entry never written; the search stops there.
		function void search(lat_t x, output bit hit, output int at, output int gap);
			int lo;
			int hi;
			int mid;
			int xs;
			int a;
			int d;
			hit = 1'b0;
			at = 0;
			gap = -1;
			if (active_len() == 0) return;
			lo = 0;
			hi = active_len() - 1;
			xs = x;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (!written[mid]) begin
					gap = mid;
					return;
				end
				a = shadow_lat[mid];
				d = xs - a;
				if (d < 0) d = -d;
				if (d <= int'(tolerance)) begin
					hit = 1'b1;
					at = mid;
					return;
				end
				if (xs < a) begin
					lo = mid + 1;
				end else begin
					// Stepping below index zero ends the search as a miss.
					if (mid == 0) return;
					hi = mid - 1;
				end
			end
		endfunction

		// Table entry that this item would read while it is still unwritten, or -1.
		function int needs_entry(logic [MODE_W-1:0] mode, lat_t x);
			bit hit;
			int at;
			int gap;
			if (mode == MODE_LOCATE) begin
				search(x, hit, at, gap);
				return gap;
			end
			if (mode == MODE_EMIT && cursor_valid && !written[cursor]) return int'(cursor);
			return -1;
		endfunction

		function void note_item(logic [MODE_W-1:0] mode, idx_t idx, lat_t x, bit north);
			row_t r;
			bit   hit;
			int   at;
			int   gap;
			int   len;
			int   limit;
			r = '{index: '0, miss: 1'b0, lat: '0, last: 1'b0};
			case (mode)
			MODE_LOAD: begin
				shadow_lat[idx] = x;
				written[idx] = 1'b1;
			end
			MODE_LOCATE: begin
				search(x, hit, at, gap);
				r.miss = !hit;
				if (hit) begin
					r.index = idx_t'(at);
					cursor = idx_t'(at);
					walk_down = north;
					rows_emitted = '0;
					cursor_valid = 1'b1;
				end else begin
					cursor_valid = 1'b0;
				end
				expected_rows.push_back(r);
			end
			MODE_EMIT: begin
				if (!cursor_valid) begin
					r.miss = 1'b1;
				end else begin
					limit = (row_count == 0) ? 1 : int'(row_count);
					rows_emitted = rows_emitted + 1'b1;
					r.last = (int'(rows_emitted) >= limit);
					if (r.last) rows_emitted = '0;
					r.index = cursor;
					r.lat = shadow_lat[cursor];
					len = active_len();
					if (walk_down) begin
						if (cursor == 0) cursor = (len == 0) ? '0 : idx_t'(len - 1);
						else cursor = cursor - 1'b1;
					end else begin
						if (int'(cursor) + 1 >= len) cursor = '0;
						else cursor = cursor + 1'b1;
					end
				end
				expected_rows.push_back(r);
			end
			default: begin
			end
			endcase
		endfunction

		function void check_row(idx_t index, logic miss, lat_t lat, logic last);
			row_t e;
			if (expected_rows.size() == 0) begin
				report("result item with none expected, found_index", index, -1);
				return;
			end
			e = expected_rows.pop_front();
			if (index !== e.index) report("found_index", index, e.index);
			if (miss !== e.miss) report("not_found", miss, e.miss);
			if (lat !== e.lat) report("row_latitude", lat, e.lat);
			if (last !== e.last) report("last_row", last, e.last);
		endfunction

		function void close();
			if (expected_rows.size() != 0) report("result items never seen", expected_rows.size(), 0);
		endfunction
	endclass

endpackage

`default_nettype wire

### tb/sv/tb_top.sv
`default_nettype none

module tb_top;

	import glw_pkg::*;
	import glw_tb_pkg::*;

	// The settle time before a register write outlasts a locate item of the largest table
	// and covers a load item that may still be in flight.
	localparam int SETTLE_CYCLES = 40;
	// The longest correct stretch without any handshake is a settle pause, a sender gap,
	// a full locate and a receiver stall.
	localparam int IDLE_LIMIT  = 2000;
	localparam int ITEM_TARGET = 1400;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [MODE_W-1:0]     mode = MODE_LOAD;
	idx_t                  entry_index = '0;
	lat_t                  latitude = '0;
	logic                  scan_north = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	idx_t                  found_index;
	logic                  not_found;
	lat_t                  row_latitude;
	logic                  last_row;

	lat_walk_board board = new();

	// Stretches with no idling on either side are switched on and off at random.
	bit in_busy = 1'b0;
	bit out_busy = 1'b0;
	int items_sent = 0;
	int idle_cycles = 0;

	// Shape of the descending table that the current phase fills in on demand.
	longint fill_top = 90000000;
	longint fill_step = 45000000;

	always #1 clk = ~clk;

	gaussian_latitude_locate_and_walk u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.entry_index  (entry_index),
		.latitude     (latitude),
		.scan_north   (scan_north),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.found_index  (found_index),
		.not_found    (not_found),
		.row_latitude (row_latitude),
		.last_row     (last_row)
	);

	function automatic int draw_gap(bit busy);
		return busy ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic lat_t clamp_lat(longint v);
		if (v > 134217727) v = 134217727;
		if (v < -134217728) v = -134217728;
		return lat_t'(v);
	endfunction

	// Entry i of a strictly descending table, with some jitter inside each step.
	function automatic lat_t fill_value(int i);
		return clamp_lat(fill_top - longint'(i) * fill_step + $urandom_range(0, fill_step / 4));
	endfunction

	// One input item: wait the drawn gap, present the item at a falling edge and hold it
	// until a rising edge sees it accepted. Valid stays high into the next call, which
	// decides whether to drop it for a gap.
	task automatic push_item(logic [MODE_W-1:0] m, idx_t idx, lat_t x, bit north);
		int gap;
		gap = draw_gap(in_busy);
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode = m;
		entry_index = idx;
		latitude = x;
		scan_north = north;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.note_item(m, idx, x, north);
		if (m != MODE_NONE) items_sent++;
		if ($urandom_range(0, 39) == 0) in_busy = !in_busy;
	endtask

	// Locate and emit items never read an entry that was never written: any such entry
	// is loaded first with its value in the phase's descending table.
	task automatic issue(logic [MODE_W-1:0] m, idx_t idx, lat_t x, bit north);
		int need;
		need = board.needs_entry(m, x);
		while (need >= 0) begin
			push_item(MODE_LOAD, idx_t'(need), fill_value(need), 1'($urandom));
			need = board.needs_entry(m, x);
		end
		push_item(m, idx, x, north);
	endtask

	// The sender pauses with valid low until every result item has arrived, then gives a
	// trailing load item time to finish.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_write = 1'b0;
		board.set_reg(index, data);
	endtask

	// The first phases hit the register extremes; later ones are random, mostly with
	// small tables and short walks. Small tables are loaded in full up front.
	task automatic start_phase(int p);
		int half;
		int tol;
		int rows;
		int len;
		case (p)
		0: begin
			half = 2048; tol = 1000; rows = 8191;
		end
		1: begin
			half = 0; tol = 0; rows = 0;
		end
		2: begin
			half = 4095; tol = 1048575; rows = 1;
		end
		3: begin
			half = 3; tol = 1000000; rows = 4096;
		end
		default: begin
			half = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 24) : $urandom_range(1, 2048);
			case ($urandom_range(0, 3))
			0: tol = 0;
			1: tol = $urandom_range(0, 5000);
			2: tol = $urandom_range(0, 200000);
			default: tol = $urandom_range(0, 1048575);
			endcase
			rows = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 12) : $urandom_range(0, 8191);
		end
		endcase
		drain();
		set_reg(CFG_HALF_COUNT, CFG_DATA_W'(half));
		set_reg(CFG_TOLERANCE, CFG_DATA_W'(tol));
		set_reg(CFG_ROW_COUNT, CFG_DATA_W'(rows));
		len = board.active_len();
		fill_top = 90000000;
		fill_step = 180000000 / ((len == 0) ? 1 : len);
		if (len <= 64) begin
			for (int i = 0; i < len; i++) push_item(MODE_LOAD, idx_t'(i), fill_value(i), 1'($urandom));
		end
	endtask

	// Sought latitudes: mostly near a table entry, often exactly on or just past the
	// tolerance edge, otherwise anywhere in the valid range or anywhere in the field.
	function automatic lat_t target_lat();
		int     len;
		int     i;
		longint tol;
		longint base;
		longint off;
		len = board.active_len();
		tol = board.tolerance;
		if (len > 0 && $urandom_range(0, 9) < 6) begin
			i = $urandom_range(0, len - 1);
			base = board.written[i] ? board.shadow_lat[i] : fill_value(i);
			case ($urandom_range(0, 4))
			0: off = tol;
			1: off = -tol;
			2: off = tol + 1;
			3: off = -tol - 1;
			default: off = longint'($urandom_range(0, 2 * tol)) - tol;
			endcase
			return clamp_lat(base + off);
		end
		if ($urandom_range(0, 3) != 0) return lat_t'(longint'($urandom_range(0, 180000000)) - 90000000);
		return lat_t'($urandom);
	endfunction

	// Random mix: emits dominate so walks run long, locates rearm the cursor, and a few
	// stray loads and dropped mode 3 items act as noise.
	task automatic random_item();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			push_item(MODE_LOAD, idx_t'($urandom), lat_t'($urandom), 1'($urandom));
		end else if (pick < 8) begin
			push_item(MODE_NONE, idx_t'($urandom), lat_t'($urandom), 1'($urandom));
		end else if (pick < 40) begin
			issue(MODE_LOCATE, idx_t'($urandom), target_lat(), 1'($urandom));
		end else begin
			issue(MODE_EMIT, idx_t'($urandom), lat_t'($urandom), 1'($urandom));
		end
	endtask

	// Directed opening on a four-entry table with a walk of three rows.
	task automatic directed();
		set_reg(CFG_HALF_COUNT, CFG_DATA_W'(2));
		set_reg(CFG_TOLERANCE, CFG_DATA_W'(1000));
		set_reg(CFG_ROW_COUNT, CFG_DATA_W'(3));
		// Emit before any locate has succeeded: no valid cursor.
		push_item(MODE_EMIT, '0, '0, 1'b0);
		push_item(MODE_LOAD, idx_t'(0), lat_t'(90000000), 1'b0);
		push_item(MODE_LOAD, idx_t'(1), lat_t'(30000000), 1'b1);
		push_item(MODE_LOAD, idx_t'(2), lat_t'(-30000000), 1'b0);
		push_item(MODE_LOAD, idx_t'(3), lat_t'(-90000000), 1'b1);
		// Field extremes loaded outside the active part.
		push_item(MODE_LOAD, idx_t'(4095), lat_t'(-134217728), 1'b1);
		push_item(MODE_LOAD, idx_t'(4094), lat_t'(134217727), 1'b0);
		// Hit on entry one, then walk up through the wrap; the third row is the last.
		push_item(MODE_LOCATE, '0, lat_t'(30000500), 1'b0);
		repeat (4) push_item(MODE_EMIT, '0, '0, 1'b0);
		// Above the first entry by more than the tolerance: the bound would drop below
		// index zero, so the search misses and the cursor is dropped.
		push_item(MODE_LOCATE, '0, lat_t'(90001001), 1'b0);
		push_item(MODE_EMIT, '0, '0, 1'b0);
		// Exactly at the tolerance below the last entry, then walk down.
		push_item(MODE_LOCATE, '0, lat_t'(-90001000), 1'b1);
		repeat (2) push_item(MODE_EMIT, '0, '0, 1'b1);
		// Between entries: the bounds cross without a match.
		push_item(MODE_LOCATE, '0, lat_t'(0), 1'b0);
		push_item(MODE_NONE, idx_t'(4095), lat_t'(-1), 1'b1);
		push_item(MODE_LOCATE, idx_t'(4095), lat_t'(-134217728), 1'b1);
		push_item(MODE_LOCATE, '0, lat_t'(134217727), 1'b0);
	endtask

	// Result side: for each result item, stall for a drawn number of cycles in which a
	// result is waiting, then take it and check it against the oldest expectation.
	initial begin : result_sink
		int hold;
		forever begin
			hold = draw_gap(out_busy);
			@(negedge clk);
			out_stall = (hold != 0);
			repeat (hold) begin
				do @(posedge clk); while (out_valid !== 1'b1);
			end
			if (hold != 0) begin
				@(negedge clk);
				out_stall = 1'b0;
			end
			do @(posedge clk); while (out_valid !== 1'b1);
			board.check_row(found_index, not_found, row_latitude, last_row);
			if ($urandom_range(0, 39) == 0) out_busy = !out_busy;
		end
	end

	// Watchdog: too many cycles in a row without any handshake means the block hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int phase;
		int target;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		directed();
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			start_phase(phase);
			phase++;
			target = items_sent + $urandom_range(60, 160);
			while (items_sent < target) random_item();
		end
		drain();
		board.close();
		if (board.errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
